// ===== hw/rtl/phase_accumulator_fm_oscillator_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the phase accumulator FM oscillator
// Concurrent checks on clk, disabled while rst_n is low; empty when SYNTH.
// ---------------------------------------------------------------------------
`ifndef PHASE_ACCUMULATOR_FM_OSCILLATOR_MACROS_SVH
`define PHASE_ACCUMULATOR_FM_OSCILLATOR_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define PAFM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PAFM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PAFM_ASSERT_IMP(label, ante, cons, msg)
`define PAFM_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/pafm_pkg.sv =====
// ---------------------------------------------------------------------------
// pafm_pkg
// Shared types, constants, sine table builder and microcode for the
// phase accumulator FM oscillator.
// ---------------------------------------------------------------------------
package pafm_pkg;

  localparam int SINE_DEPTH = 1024;
  localparam int ADDR_BITS  = 10;
  localparam int SINE_W     = 16;
  localparam int CFG_W      = 32;
  localparam int OPA_W      = 18;
  localparam int OPB_W      = 17;
  localparam int PROD_W     = OPA_W + OPB_W;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [15:0] UNITY_Q15   = 16'd32768;
  localparam logic [15:0] FM_IDX_MAX  = 16'd40960;

  localparam logic [1:0] MODE_SINE  = 2'd0;
  localparam logic [1:0] MODE_MORPH = 2'd1;
  localparam logic [1:0] MODE_FM    = 2'd2;

  typedef enum logic [2:0] {
    REG_WAVE_MODE    = 3'd0,
    REG_CARRIER_STEP = 3'd1,
    REG_MOD_STEP     = 3'd2,
    REG_FM_INDEX     = 3'd3,
    REG_MORPH        = 3'd4,
    REG_LEVEL        = 3'd5,
    REG_PAN          = 3'd6,
    REG_VELOCITY     = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [CFG_W-1:0] car_step;
    logic [CFG_W-1:0] mod_step;
    logic [15:0]      fm_index;
    logic [15:0]      morph;
    logic [15:0]      level;
    logic [15:0]      pan;
    logic [15:0]      velocity;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    OPA_ROM,
    OPA_SQ_DIFF,
    OPA_WAVE,
    OPA_RQ,
    OPA_HOLD_C
  } opa_sel_t;

  typedef enum logic [2:0] {
    OPB_FM_INDEX,
    OPB_MORPH,
    OPB_ENV,
    OPB_VEL,
    OPB_LEVEL,
    OPB_PAN_L,
    OPB_PAN_R
  } opb_sel_t;

  typedef enum logic {
    ADDR_MOD,
    ADDR_CAR
  } addr_sel_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_NOT_FM,
    COND_OUT_BUSY
  } cond_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef logic [3:0] step_t;

  localparam step_t STEP_RD_MOD = 4'd0;
  localparam step_t STEP_FM_MUL = 4'd1;
  localparam step_t STEP_RD_CAR = 4'd2;
  localparam step_t STEP_MORPH  = 4'd3;
  localparam step_t STEP_ENV    = 4'd4;
  localparam step_t STEP_VEL    = 4'd5;
  localparam step_t STEP_LEVEL  = 4'd6;
  localparam step_t STEP_LEFT   = 4'd7;
  localparam step_t STEP_RIGHT  = 4'd8;
  localparam step_t STEP_DONE   = 4'd9;

  typedef struct packed {
    logic      mul_en;
    opa_sel_t  opa;
    opb_sel_t  opb;
    addr_sel_t addr;
    logic      ld_sine;
    logic      ld_c;
    logic      ld_left;
    logic      ld_out;
    cond_t     cond;
    step_t     target;
    logic      last;
  } ctrl_word_t;

  typedef struct packed {
    logic not_fm;
    logic out_busy;
  } seq_cond_t;

  localparam ctrl_word_t CW_NOP = '{
    mul_en: 1'b0, opa: OPA_ROM, opb: OPB_ENV, addr: ADDR_CAR,
    ld_sine: 1'b0, ld_c: 1'b0, ld_left: 1'b0, ld_out: 1'b0,
    cond: COND_NONE, target: STEP_RD_MOD, last: 1'b0
  };

  typedef logic signed [SINE_W-1:0] sine_rom_t [SINE_DEPTH];

  // Microcode program, one control word per step
  function automatic ctrl_word_t ucode(input step_t step);
    ctrl_word_t w;
    w = CW_NOP;
    case (step)
      STEP_RD_MOD: begin
        w.addr   = ADDR_MOD;
        w.cond   = COND_NOT_FM;
        w.target = STEP_RD_CAR;
      end
      STEP_FM_MUL: begin
        w.mul_en = 1'b1;
        w.opa    = OPA_ROM;
        w.opb    = OPB_FM_INDEX;
      end
      STEP_RD_CAR: begin
        w.addr = ADDR_CAR;
      end
      STEP_MORPH: begin
        w.mul_en  = 1'b1;
        w.opa     = OPA_SQ_DIFF;
        w.opb     = OPB_MORPH;
        w.ld_sine = 1'b1;
      end
      STEP_ENV: begin
        w.mul_en = 1'b1;
        w.opa    = OPA_WAVE;
        w.opb    = OPB_ENV;
      end
      STEP_VEL: begin
        w.mul_en = 1'b1;
        w.opa    = OPA_RQ;
        w.opb    = OPB_VEL;
      end
      STEP_LEVEL: begin
        w.mul_en = 1'b1;
        w.opa    = OPA_RQ;
        w.opb    = OPB_LEVEL;
      end
      STEP_LEFT: begin
        w.mul_en = 1'b1;
        w.opa    = OPA_RQ;
        w.opb    = OPB_PAN_L;
        w.ld_c   = 1'b1;
      end
      STEP_RIGHT: begin
        w.mul_en  = 1'b1;
        w.opa     = OPA_HOLD_C;
        w.opb     = OPB_PAN_R;
        w.ld_left = 1'b1;
      end
      STEP_DONE: begin
        w.ld_out = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.last   = 1'b1;
      end
      default: w = CW_NOP;
    endcase
    return w;
  endfunction

  function automatic logic [15:0] sat_unity(input logic [15:0] v);
    return (v > UNITY_Q15) ? UNITY_Q15 : v;
  endfunction

  function automatic logic [15:0] sat_fm_index(input logic [15:0] v);
    return (v > FM_IDX_MAX) ? FM_IDX_MAX : v;
  endfunction

  // sin(pi/2 * r / SINE_DEPTH) in Q15, Taylor series in Q30 up to degree 13
  function automatic logic signed [SINE_W-1:0] quarter_sine(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q;
    x    = (HALF_PI_Q30 * r) / SINE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    q    = (sum + 64'd16384) >> 15;
    return (q > 64'd32767) ? 16'sd32767 : signed'(q[SINE_W-1:0]);
  endfunction

  // Full table from quarter-wave symmetry, evaluated at elaboration
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t                rom;
    logic [63:0]              t;
    logic [63:0]              quad;
    logic [63:0]              rem;
    logic signed [SINE_W-1:0] v;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      t    = 64'(4 * i);
      quad = t / SINE_DEPTH;
      rem  = t - quad * SINE_DEPTH;
      v    = quad[0] ? quarter_sine(64'(SINE_DEPTH) - rem) : quarter_sine(rem);
      rom[i] = quad[1] ? -v : v;
    end
    return rom;
  endfunction

endpackage

// ===== hw/rtl/pafm_sine_rom.sv =====
// ---------------------------------------------------------------------------
// pafm_sine_rom
// Full-cycle Q15 sine table with one registered read port.
// ---------------------------------------------------------------------------
module pafm_sine_rom (
  input  logic                                 clk,
  input  logic [pafm_pkg::ADDR_BITS-1:0]       addr_i,
  output logic signed [pafm_pkg::SINE_W-1:0]   data_o
);
  import pafm_pkg::*;

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic signed [SINE_W-1:0] data_r;

  always_ff @(posedge clk) begin
    data_r <= SINE_ROM[addr_i];
  end

  assign data_o = data_r;

endmodule

// ===== hw/rtl/pafm_seq.sv =====
// ---------------------------------------------------------------------------
// pafm_seq
// Step counter and microcode fetch; a control word per cycle unless stalled.
// ---------------------------------------------------------------------------
module pafm_seq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start_i,
  input  pafm_pkg::seq_cond_t    cond_i,
  output pafm_pkg::ctrl_word_t   ctrl_o,
  output logic                   busy_o
);
  import pafm_pkg::*;

  seq_state_t state_r, state_nxt;
  step_t      step_r, step_nxt;
  ctrl_word_t word;
  logic       hold;

  always_comb begin
    word = ucode(step_r);
    hold = (word.cond == COND_OUT_BUSY) && cond_i.out_busy;
  end

  // next state and step
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      SEQ_IDLE: begin
        if (start_i) begin
          state_nxt = SEQ_RUN;
          step_nxt  = STEP_RD_MOD;
        end
      end
      SEQ_RUN: begin
        if (!hold) begin
          if (word.last) begin
            state_nxt = SEQ_IDLE;
          end else if ((word.cond == COND_NOT_FM) && cond_i.not_fm) begin
            step_nxt = word.target;
          end else begin
            step_nxt = step_r + step_t'(1);
          end
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o = CW_NOP;
    busy_o = 1'b0;
    case (state_r)
      SEQ_RUN: begin
        busy_o = 1'b1;
        if (!hold) begin
          ctrl_o = word;
        end
      end
      default: ctrl_o = CW_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      step_r  <= STEP_RD_MOD;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ===== hw/rtl/pafm_datapath.sv =====
// ---------------------------------------------------------------------------
// pafm_datapath
// Phase accumulators, sine table port, shared multiplier with Q15 rounding,
// saturation and the output register.
// ---------------------------------------------------------------------------
module pafm_datapath #(
  parameter int PHASE_BITS  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start_i,
  input  logic [15:0]                   env_i,
  input  pafm_pkg::cfg_regs_t           cfg_i,
  input  pafm_pkg::ctrl_word_t          ctrl_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic signed [SAMPLE_BITS-1:0] left_o,
  output logic signed [SAMPLE_BITS-1:0] right_o,
  output pafm_pkg::seq_cond_t           cond_o
);
  import pafm_pkg::*;

  localparam int EXT_W  = PHASE_BITS + PROD_W;
  localparam int FM_SHL = (PHASE_BITS >= 27) ? PHASE_BITS - 27 : 0;
  localparam int FM_SHR = (PHASE_BITS >= 27) ? 0 : 27 - PHASE_BITS;

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(16384);
  localparam logic signed [PROD_W-1:0] SAT_HI   =
    PROD_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [PROD_W-1:0] SAT_LO   = ~SAT_HI;
  localparam logic signed [OPA_W-1:0]  SQ_POS   = OPA_W'(32768);
  localparam logic signed [OPA_W-1:0]  SQ_NEG   = -SQ_POS;

  logic [PHASE_BITS-1:0]         carrier_r, mod_r;
  logic [PHASE_BITS-1:0]         carrier_nxt, mod_nxt, fm_off, car_sum;
  logic signed [EXT_W-1:0]       off_ext, off_sh;
  logic [ADDR_BITS-1:0]          rom_addr;
  logic signed [SINE_W-1:0]      rom_q;
  logic signed [PROD_W-1:0]      prod_r, rq;
  logic signed [OPA_W-1:0]       opa, sq_val, c_r;
  logic signed [OPB_W-1:0]       opb;
  logic signed [SINE_W-1:0]      sine_r;
  logic [15:0]                   env_r;
  logic signed [SAMPLE_BITS-1:0] sat_q, left_r, out_left_r, out_right_r;
  logic                          out_valid_r;
  logic                          is_fm, is_morph;

  assign is_fm    = (cfg_i.mode == MODE_FM);
  assign is_morph = (cfg_i.mode == MODE_MORPH);

  // FM offset: product is Q5.27 cycles, move it to the phase fraction
  always_comb begin
    off_ext = EXT_W'(prod_r);
    off_sh  = (off_ext <<< FM_SHL) >>> FM_SHR;
    fm_off  = off_sh[PHASE_BITS-1:0];
    car_sum = carrier_r + (is_fm ? fm_off : '0);
  end

  assign rom_addr = (ctrl_i.addr == ADDR_MOD) ? mod_r[PHASE_BITS-1 -: ADDR_BITS]
                                               : car_sum[PHASE_BITS-1 -: ADDR_BITS];

  pafm_sine_rom u_rom (
    .clk    (clk),
    .addr_i (rom_addr),
    .data_o (rom_q)
  );

  assign rq     = (prod_r + RND_HALF) >>> 15;
  assign sq_val = carrier_r[PHASE_BITS-1] ? SQ_NEG : SQ_POS;

  always_comb begin
    if (rq > SAT_HI) begin
      sat_q = SAMPLE_BITS'(SAT_HI);
    end else if (rq < SAT_LO) begin
      sat_q = SAMPLE_BITS'(SAT_LO);
    end else begin
      sat_q = SAMPLE_BITS'(rq);
    end
  end

  always_comb begin
    case (ctrl_i.opa)
      OPA_ROM:     opa = OPA_W'(rom_q);
      OPA_SQ_DIFF: opa = sq_val - OPA_W'(rom_q);
      OPA_WAVE:    opa = OPA_W'(sine_r) + rq[OPA_W-1:0];
      OPA_RQ:      opa = rq[OPA_W-1:0];
      OPA_HOLD_C:  opa = c_r;
      default:     opa = '0;
    endcase
  end

  always_comb begin
    case (ctrl_i.opb)
      OPB_FM_INDEX: opb = {1'b0, cfg_i.fm_index};
      OPB_MORPH:    opb = {1'b0, (is_morph ? cfg_i.morph : 16'd0)};
      OPB_ENV:      opb = {1'b0, env_r};
      OPB_VEL:      opb = {1'b0, cfg_i.velocity};
      OPB_LEVEL:    opb = {1'b0, cfg_i.level};
      OPB_PAN_L:    opb = {1'b0, UNITY_Q15 - cfg_i.pan};
      OPB_PAN_R:    opb = {1'b0, cfg_i.pan};
      default:      opb = '0;
    endcase
  end

  assign carrier_nxt = carrier_r + PHASE_BITS'(cfg_i.car_step);
  assign mod_nxt     = mod_r + PHASE_BITS'(cfg_i.mod_step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_r   <= '0;
      mod_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl_i.ld_out) begin
        carrier_r   <= carrier_nxt;
        out_valid_r <= 1'b1;
        if (is_fm) begin
          mod_r <= mod_nxt;
        end
      end else if (out_valid_r && !out_stall_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      env_r <= env_i;
    end
    if (ctrl_i.mul_en) begin
      prod_r <= opa * opb;
    end
    if (ctrl_i.ld_sine) begin
      sine_r <= rom_q;
    end
    if (ctrl_i.ld_c) begin
      c_r <= rq[OPA_W-1:0];
    end
    if (ctrl_i.ld_left) begin
      left_r <= sat_q;
    end
    if (ctrl_i.ld_out) begin
      out_left_r  <= left_r;
      out_right_r <= sat_q;
    end
  end

  assign cond_o.not_fm   = !is_fm;
  assign cond_o.out_busy = out_valid_r && out_stall_i;
  assign out_valid_o     = out_valid_r;
  assign left_o          = out_left_r;
  assign right_o         = out_right_r;

endmodule

// ===== hw/rtl/phase_accumulator_fm_oscillator.sv =====
// ---------------------------------------------------------------------------
// phase_accumulator_fm_oscillator
// Sine oscillator with sine-to-square morph and phase modulation, scaled by
// envelope, velocity and level and panned to a saturated stereo pair. Each
// input transaction is one sample tick. A tick with gate low is taken at
// once and gives no result and leaves both phases alone. A tick with gate
// high runs a ten-step microcode program (nine steps outside FM mode, which
// skips the modulator multiply) on one shared 18x17 multiplier and one
// registered sine-table port, so the input takes no new tick until the
// program ends; a result that is still stalled holds the last step until
// it is taken. Configuration writes are taken in any cycle (cfg_ready stays
// high) and must only happen while no tick is in flight. Gains, pan, morph
// position and envelope saturate at 1.0, the FM index at 10.0; wave mode 3
// plays as sine.
// ---------------------------------------------------------------------------
`include "phase_accumulator_fm_oscillator_macros.svh"

module phase_accumulator_fm_oscillator #(
  parameter int PHASE_BITS  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input transaction: one sample tick
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [15:0]                   in_envelope_level,
  input  logic                          in_gate,
  // result transaction: one stereo sample
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_left_sample,
  output logic signed [SAMPLE_BITS-1:0] out_right_sample,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_wdata
);
  import pafm_pkg::*;

  cfg_regs_t  cfg_r;
  ctrl_word_t ctrl;
  seq_cond_t  cond;
  logic       seq_busy;
  logic       in_take;
  logic       start;
  logic [15:0] env_sat;

  assign cfg_ready = 1'b1;

  // Hold off new ticks while the program runs; drop gate-low ticks at once.
  assign in_stall = seq_busy;
  assign in_take  = in_valid && !in_stall;
  assign start    = in_take && in_gate;
  assign env_sat  = sat_unity(in_envelope_level);

  // Register file: saturate on write so the datapath sees legal values only.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode     <= MODE_SINE;
      cfg_r.car_step <= '0;
      cfg_r.mod_step <= '0;
      cfg_r.fm_index <= '0;
      cfg_r.morph    <= '0;
      cfg_r.level    <= UNITY_Q15;
      cfg_r.pan      <= 16'd16384;
      cfg_r.velocity <= UNITY_Q15;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_WAVE_MODE:    cfg_r.mode     <= cfg_wdata[1:0];
        REG_CARRIER_STEP: cfg_r.car_step <= cfg_wdata;
        REG_MOD_STEP:     cfg_r.mod_step <= cfg_wdata;
        REG_FM_INDEX:     cfg_r.fm_index <= sat_fm_index(cfg_wdata[15:0]);
        REG_MORPH:        cfg_r.morph    <= sat_unity(cfg_wdata[15:0]);
        REG_LEVEL:        cfg_r.level    <= sat_unity(cfg_wdata[15:0]);
        REG_PAN:          cfg_r.pan      <= sat_unity(cfg_wdata[15:0]);
        REG_VELOCITY:     cfg_r.velocity <= sat_unity(cfg_wdata[15:0]);
        default:          cfg_r.mode     <= cfg_r.mode;
      endcase
    end
  end

  // Step through the program and drive the datapath one control word a cycle unless a stalled result holds it.
  pafm_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (start),
    .cond_i  (cond),
    .ctrl_o  (ctrl),
    .busy_o  (seq_busy)
  );

  // Advance phases, multiply, round, saturate and hold the result.
  pafm_datapath #(
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (start),
    .env_i       (env_sat),
    .cfg_i       (cfg_r),
    .ctrl_i      (ctrl),
    .out_stall_i (out_stall),
    .out_valid_o (out_valid),
    .left_o      (out_left_sample),
    .right_o     (out_right_sample),
    .cond_o      (cond)
  );

  // A gate-high tick starts the program and blocks the input.
  `PAFM_ASSERT_NEXT(a_start_busy, in_valid && !in_stall && in_gate, in_stall, "tick did not start program")
  // A gate-low tick taken while idle with no pending result creates none.
  `PAFM_ASSERT_NEXT(a_gate_low_silent, in_valid && !in_stall && !in_gate && !out_valid, !out_valid, "gate-low tick produced a result")
  // A result only appears at the end of a running program.
  `PAFM_ASSERT_IMP(a_result_from_run, $rose(out_valid), $past(in_stall), "result without a running program")

endmodule
